FILE: src/gammatone_complex_bandpass_defines.svh
// Assertion macros used by the checker file of the gammatone band-pass
`ifndef GAMMATONE_COMPLEX_BANDPASS_DEFINES_SVH
`define GAMMATONE_COMPLEX_BANDPASS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define GCB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("gcb assertion failed");

// next-cycle implication, disabled in reset
`define GCB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("gcb assertion failed");

`endif

FILE: src/gcb_pkg.sv
// Types and constants of the gammatone complex band-pass block
package gcb_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_POLE_REAL   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLE_IMAG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN = 2'd2;

	localparam int COEF_W = 18;
	localparam int GAIN_W = 32;
	// multiplier operand width: 32-bit chunk plus sign
	localparam int OPND_W = 33;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               block_end;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] filtered;
		logic               clipped;
		logic               block_end_out;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DRAIN,
		ST_FIN,
		ST_GMUL,
		ST_GDRAIN,
		ST_RES
	} gcb_state_t;

	typedef struct packed {
		logic load;     // capture input beat
		logic mul;      // issue one partial product per lane
		logic hi;       // upper 32-bit chunk of the state word
		logic pole_im;  // second product pair (imaginary pole part)
		logic gain;     // output gain pass
		logic acc_clr;  // preload accumulators with rounding half
		logic fin;      // round, add, saturate and store section result
		logic res_wr;   // load output register
	} gcb_cmd_t;

endpackage

FILE: src/gcb_ctrl.sv
// Sequencer: walks the sections and the output gain pass, owns output valid
module gcb_ctrl #(
	parameter int SECTIONS = 4,
	parameter int SEC_W    = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	output gcb_pkg::gcb_cmd_t cmd,
	output logic [SEC_W-1:0] sec
);
	import gcb_pkg::*;

	gcb_state_t       state_q, state_d;
	logic [1:0]       step_q;
	logic [SEC_W-1:0] sec_q;
	logic             out_vld_q;
	logic             last_sec;

	assign last_sec  = (sec_q == SEC_W'(SECTIONS - 1));
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_vld_q;
	assign sec       = sec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul     = 1'b1;
				cmd.hi      = step_q[0];
				cmd.pole_im = step_q[1];
				cmd.acc_clr = (step_q == 2'd0);
				if (step_q == 2'd3) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = last_sec ? ST_GMUL : ST_MUL;
			end
			ST_GMUL: begin
				cmd.mul     = 1'b1;
				cmd.gain    = 1'b1;
				cmd.hi      = step_q[0];
				cmd.acc_clr = (step_q == 2'd0);
				if (step_q == 2'd1) begin
					state_d = ST_GDRAIN;
				end
			end
			ST_GDRAIN: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				// output register free, or its beat leaves this edge
				if (!out_vld_q || !out_stall) begin
					cmd.res_wr = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			sec_q  <= '0;
		end else begin
			if (cmd.load) begin
				sec_q <= '0;
			end else if (cmd.fin && !last_sec) begin
				sec_q <= sec_q + SEC_W'(1);
			end
			if (cmd.mul && state_d == state_q) begin
				step_q <= step_q + 2'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.res_wr) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

endmodule

FILE: src/gcb_dp.sv
// Datapath: config registers, section state, two multiply-accumulate lanes
module gcb_dp #(
	parameter int SECTIONS   = 4,
	parameter int STATE_BITS = 48,
	parameter int SEC_W      = 2
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gcb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gcb_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  gcb_pkg::in_item_t                  in_item,
	input  gcb_pkg::gcb_cmd_t                  cmd,
	input  logic [SEC_W-1:0]                   sec,
	output gcb_pkg::out_item_t                 res
);
	import gcb_pkg::*;

	localparam int PROD_W = 2 * OPND_W;
	localparam int ACC_W  = STATE_BITS + 35;
	localparam int RND_W  = ACC_W - 17;
	localparam int G_W    = ACC_W - 47;
	localparam logic signed [ACC_W-1:0] HALF_P = ACC_W'(1) <<< 16;
	localparam logic signed [ACC_W-1:0] HALF_G = ACC_W'(1) <<< 46;

	logic signed [COEF_W-1:0]     pole_real_q, pole_imag_q;
	logic        [GAIN_W-1:0]     gain_q;
	logic signed [STATE_BITS-1:0] sec_re_q [SECTIONS];
	logic signed [STATE_BITS-1:0] sec_im_q [SECTIONS];
	logic signed [STATE_BITS-1:0] x_re_q, x_im_q;
	logic                         blk_q;
	out_item_t                    res_q;

	logic signed [PROD_W-1:0] prod_re_s1, prod_im_s1;
	logic                     pvld_s1, phi_s1, psub_s1;
	logic signed [ACC_W-1:0]  acc_re_q, acc_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_real_q <= '0;
			pole_imag_q <= '0;
			gain_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_POLE_REAL:   pole_real_q <= cfg_data[COEF_W-1:0];
				CFG_POLE_IMAG:   pole_imag_q <= cfg_data[COEF_W-1:0];
				CFG_OUTPUT_GAIN: gain_q      <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// operand selection
	logic signed [STATE_BITS-1:0] s_re, s_im, src_re, src_im;
	logic signed [63:0]           sx_re, sx_im;
	logic signed [OPND_W-1:0]     mul_a, mul_b_re, mul_b_im;

	always_comb begin
		s_re   = sec_re_q[sec];
		s_im   = sec_im_q[sec];
		src_re = cmd.gain ? x_re_q : (cmd.pole_im ? s_im : s_re);
		src_im = cmd.pole_im ? s_re : s_im;
		sx_re  = 64'(src_re);
		sx_im  = 64'(src_im);
		if (cmd.gain) begin
			mul_a = signed'({1'b0, gain_q});
		end else begin
			mul_a = OPND_W'(cmd.pole_im ? pole_imag_q : pole_real_q);
		end
		mul_b_re = cmd.hi ? signed'({sx_re[63], sx_re[63:32]}) : signed'({1'b0, sx_re[31:0]});
		mul_b_im = cmd.hi ? signed'({sx_im[63], sx_im[63:32]}) : signed'({1'b0, sx_im[31:0]});
	end

	always_ff @(posedge clk) begin
		prod_re_s1 <= mul_a * mul_b_re;
		prod_im_s1 <= mul_a * mul_b_im;
		phi_s1     <= cmd.hi;
		psub_s1    <= cmd.pole_im && !cmd.gain;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s1 <= 1'b0;
		end else begin
			pvld_s1 <= cmd.mul;
		end
	end

	// accumulate, with upper chunk products weighted by 2^32
	logic signed [ACC_W-1:0] ext_re, ext_im;

	always_comb begin
		ext_re = ACC_W'(prod_re_s1);
		ext_im = ACC_W'(prod_im_s1);
		if (phi_s1) begin
			ext_re = ext_re <<< 32;
			ext_im = ext_im <<< 32;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_re_q <= cmd.gain ? HALF_G : HALF_P;
			acc_im_q <= HALF_P;
		end else if (pvld_s1) begin
			acc_re_q <= psub_s1 ? acc_re_q - ext_re : acc_re_q + ext_re;
			acc_im_q <= acc_im_q + ext_im;
		end
	end

	// round (half already preloaded), add incoming value, saturate
	logic signed [RND_W-1:0]      sum_re, sum_im;
	logic signed [STATE_BITS-1:0] y_re, y_im;

	always_comb begin
		sum_re = RND_W'(acc_re_q >>> 17) + RND_W'(x_re_q);
		sum_im = RND_W'(acc_im_q >>> 17) + RND_W'(x_im_q);
		if (sum_re[RND_W-1:STATE_BITS-1] == '0 || sum_re[RND_W-1:STATE_BITS-1] == '1) begin
			y_re = sum_re[STATE_BITS-1:0];
		end else begin
			y_re = {sum_re[RND_W-1], {(STATE_BITS-1){~sum_re[RND_W-1]}}};
		end
		if (sum_im[RND_W-1:STATE_BITS-1] == '0 || sum_im[RND_W-1:STATE_BITS-1] == '1) begin
			y_im = sum_im[STATE_BITS-1:0];
		end else begin
			y_im = {sum_im[RND_W-1], {(STATE_BITS-1){~sum_im[RND_W-1]}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SECTIONS; i++) begin
				sec_re_q[i] <= '0;
				sec_im_q[i] <= '0;
			end
		end else if (cmd.fin) begin
			sec_re_q[sec] <= y_re;
			sec_im_q[sec] <= y_im;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_re_q <= STATE_BITS'(signed'({in_item.sample, 16'h0000}));
			x_im_q <= '0;
			blk_q  <= in_item.block_end;
		end else if (cmd.fin) begin
			x_re_q <= y_re;
			x_im_q <= y_im;
		end
	end

	// output scaling: 31 gain plus 16 state fraction bits dropped
	logic signed [G_W-1:0] g_val;
	out_item_t             res_d;

	always_comb begin
		g_val = G_W'(acc_re_q >>> 47);
		res_d.block_end_out = blk_q;
		if (g_val[G_W-1:15] == '0 || g_val[G_W-1:15] == '1) begin
			res_d.filtered = g_val[15:0];
			res_d.clipped  = 1'b0;
		end else begin
			res_d.filtered = {g_val[G_W-1], {15{~g_val[G_W-1]}}};
			res_d.clipped  = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_wr) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

FILE: src/gammatone_complex_bandpass.sv
// Top level of the complex gammatone band-pass filter
//
// One real 16-bit sample per input beat runs through SECTIONS cascaded
// complex one-pole sections (Q1.17 pole, STATE_BITS-wide state with 16
// fraction bits); the real part of the last section is scaled by the Q1.31
// gain, rounded and saturated to 16 bits, with a clip flag and block_end
// echoed. One item at a time: each section takes four multiply steps on a
// pair of 33x33 multipliers (real and imaginary lanes), a drain step and a
// store step, and the gain pass runs its own multiply, drain and result
// write steps. The finished result sits in an output register, so the next
// sample is taken while it waits. Pole and gain registers may only be
// written while idle.
module gammatone_complex_bandpass #(
	parameter int SECTIONS   = 4,
	parameter int STATE_BITS = 48
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gcb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gcb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  gcb_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output gcb_pkg::out_item_t             out_item
);
	import gcb_pkg::*;

	localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	gcb_cmd_t         cmd;
	logic [SEC_W-1:0] sec;

	gcb_ctrl #(
		.SECTIONS (SECTIONS),
		.SEC_W    (SEC_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sec       (sec)
	);

	gcb_dp #(
		.SECTIONS   (SECTIONS),
		.STATE_BITS (STATE_BITS),
		.SEC_W      (SEC_W)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.cmd       (cmd),
		.sec       (sec),
		.res       (out_item)
	);

endmodule

FILE: src/gcb_checker.sv
// Port-level checks on the band-pass top level, bound in below
`include "gammatone_complex_bandpass_defines.svh"

module gcb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input gcb_pkg::out_item_t             out_item
);

	// a stalled result beat stays put
	`GCB_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(out_item))

	// an accepted sample keeps the block busy on the next cycle
	`GCB_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	// a fresh result only comes out of a busy block
	`GCB_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind gammatone_complex_bandpass gcb_checker u_gcb_checker (.*);
